@@ design/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Constants and hue weight functions for the 8-bit HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int unsigned FullW     = 255;
    localparam int unsigned HueSpan   = 1530;
    localparam int unsigned Denom     = 65025;      // 255 * 255
    localparam int unsigned RecipBits = 25;
    localparam int unsigned RecipShift = 40;
    // ceil(2^40 / 65025); exact floor division for any 24-bit numerator
    localparam logic [RecipBits-1:0] Recip = 25'd16909061;

    typedef logic signed [12:0] wsum_t;

    function automatic logic [7:0] clamp_w(input wsum_t x);
        logic [7:0] r;
        begin
            if (x < 0)
            begin
                r = 8'd0;
            end
            else if (x > wsum_t'(FullW))
            begin
                r = 8'(FullW);
            end
            else
            begin
                r = x[7:0];
            end
            return r;
        end
    endfunction

    function automatic wsum_t pos_part(input wsum_t x);
        return (x > 0) ? x : wsum_t'(0);
    endfunction

    function automatic logic [7:0] weight_red(input logic [10:0] p);
        wsum_t ps;
        begin
            ps = wsum_t'({2'b00, p});
            return 8'(FullW) - clamp_w(ps - wsum_t'(FullW)
                                       - 13'(2 * pos_part(ps - wsum_t'(3 * FullW))));
        end
    endfunction

    function automatic logic [7:0] weight_green(input logic [10:0] p);
        wsum_t ps;
        begin
            ps = wsum_t'({2'b00, p});
            return clamp_w(ps - 13'(2 * pos_part(ps - wsum_t'(2 * FullW))));
        end
    endfunction

    function automatic logic [7:0] weight_blue(input logic [10:0] p);
        return weight_green(11'(HueSpan) - p);
    endfunction

endpackage

@@ design/hsv_to_rgb_8bit.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_8bit
// Four-stage pipelined HSV to RGB pixel converter, alpha passed through.
// ----------------------------------------------------------------------------
// One pixel word in, one pixel word out. Throughput is one word per clock
// while the output side accepts; each word passes through the stages below
// in order, and the output word is registered.
// Stages: hue weights, saturation loss multiply, brightness multiply, and a
// reciprocal multiply that divides by 65025. Each stage holds its word until
// the next stage frees up, so back-pressure from the output stalls no more
// of the pipeline than needed and nothing is dropped or repeated.
module hsv_to_rgb_8bit
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue, saturation, brightness, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // red, green, blue, alpha_out
);

    // stage valids
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic en1, en2, en3, en4;

    // stage 1: weights
    logic [7:0]  sat1_reg, val1_reg, alp1_reg;
    logic [7:0]  wgt1_reg [3];
    logic [10:0] p_next;

    // stage 2: per-channel 65025 - s*(255-M)
    logic [7:0]  val2_reg, alp2_reg;
    logic [15:0] diff2_reg [3];
    logic [15:0] diff2_next [3];

    // stage 3: v * diff
    logic [7:0]  alp3_reg;
    logic [23:0] num3_reg [3];

    // stage 4: quotient
    logic [7:0]  alp4_reg;
    logic [7:0]  q4_reg [3];
    logic [48:0] prod_next [3];

    assign en4 = !vld4_reg || m_axis_tready;
    assign en3 = !vld3_reg || en4;
    assign en2 = !vld2_reg || en3;
    assign en1 = !vld1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                vld1_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                vld2_reg <= vld1_reg;
            end
            if (en3)
            begin
                vld3_reg <= vld2_reg;
            end
            if (en4)
            begin
                vld4_reg <= vld3_reg;
            end
        end
    end

    assign p_next = 11'(s_axis_tdata[7:0]) * 11'd6;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff2_next[i] = 16'(Denom)
                - (16'(sat1_reg) * 16'(8'(FullW) - wgt1_reg[i]));
            prod_next[i]  = 49'(num3_reg[i]) * 49'(Recip);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            sat1_reg    <= s_axis_tdata[15:8];
            val1_reg    <= s_axis_tdata[23:16];
            alp1_reg    <= s_axis_tdata[31:24];
            wgt1_reg[0] <= weight_red(p_next);
            wgt1_reg[1] <= weight_green(p_next);
            wgt1_reg[2] <= weight_blue(p_next);
        end
        if (en2 && vld1_reg)
        begin
            val2_reg  <= val1_reg;
            alp2_reg  <= alp1_reg;
            diff2_reg <= diff2_next;
        end
        if (en3 && vld2_reg)
        begin
            alp3_reg <= alp2_reg;
            for (int i = 0; i < 3; i++)
            begin
                num3_reg[i] <= 24'(val2_reg) * 24'(diff2_reg[i]);
            end
        end
        if (en4 && vld3_reg)
        begin
            alp4_reg <= alp3_reg;
            for (int i = 0; i < 3; i++)
            begin
                q4_reg[i] <= prod_next[i][RecipShift+7:RecipShift];
            end
        end
    end

    assign m_axis_tvalid = vld4_reg;
    assign m_axis_tdata  = {alp4_reg, q4_reg[2], q4_reg[1], q4_reg[0]};

endmodule

@@ dv/hsv_to_rgb_8bit_test.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_8bit_test
// Self-checking bench for the 8-bit HSV to RGB converter. Pixel words go in
// through the slave stream in random bursts while the master side stalls on
// its own pattern. Each accepted pixel is converted by an integer model of
// the hue trapezoids and the saturation/brightness scaling, and every output
// word is compared channel by channel in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_8bit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ChanMax       = 255;
    localparam int HueRange      = 1530;
    localparam int ScaleDiv      = 65025;
    localparam int SettleCycles  = 8;
    localparam int WatchdogLimit = 2000;
    localparam int RandomPixels  = 480;

    // packed so that the last field sits in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] brightness;
        logic [7:0] saturation;
        logic [7:0] hue;
    } hsva_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // hue, saturation, brightness, alpha_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // red, green, blue, alpha_out

    rgba_t expected_pixels[$];
    int    fail_count = 0;
    int    burst_left = 0;
    int    idle_cycles = 0;

    hsv_to_rgb_8bit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_weight(input int x);
        if (x < 0)
        begin
            return 0;
        end
        if (x > ChanMax)
        begin
            return ChanMax;
        end
        return x;
    endfunction

    function automatic int ramp_pos(input int x);
        return (x > 0) ? x : 0;
    endfunction

    function automatic int green_weight(input int p);
        return clamp_weight(p - 2 * ramp_pos(p - 2 * ChanMax));
    endfunction

    function automatic logic [7:0] scale_channel(input int v, input int s, input int m);
        int prod;
        prod = v * (ScaleDiv - s * (ChanMax - m));
        return 8'(prod / ScaleDiv);
    endfunction

    function automatic rgba_t convert_pixel(input hsva_t px);
        rgba_t res;
        int    p;
        int    w_red;
        int    w_green;
        int    w_blue;
        p       = 6 * int'(px.hue);
        w_red   = ChanMax - clamp_weight(p - ChanMax - 2 * ramp_pos(p - 3 * ChanMax));
        w_green = green_weight(p);
        w_blue  = green_weight(HueRange - p);
        res.red   = scale_channel(px.brightness, px.saturation, w_red);
        res.green = scale_channel(px.brightness, px.saturation, w_green);
        res.blue  = scale_channel(px.brightness, px.saturation, w_blue);
        res.alpha = px.alpha;
        return res;
    endfunction

    function automatic hsva_t make_pixel(input int h, input int s, input int v, input int a);
        hsva_t px;
        px.hue        = 8'(h);
        px.saturation = 8'(s);
        px.brightness = 8'(v);
        px.alpha      = 8'(a);
        return px;
    endfunction

    // biased toward the ends of the range
    function automatic int pick_byte();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return ChanMax;
            default: return $urandom_range(0, ChanMax);
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_pixel(input hsva_t px);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap)
                begin
                    s_axis_tdata <= $urandom;
                    @(negedge clk);
                end
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_pixels.push_back(convert_pixel(px));
        burst_left--;
        @(negedge clk);
    endtask

    task automatic test_hue_sectors();
        int hues[10] = '{0, 42, 43, 85, 127, 128, 170, 212, 213, 255};
        foreach (hues[i])
        begin
            send_pixel(make_pixel(hues[i], ChanMax, ChanMax, hues[i]));
        end
        send_pixel(make_pixel(100, 128, 200, 77));
        send_pixel(make_pixel(200, 1, 254, 1));
    endtask

    task automatic test_zero_saturation();
        send_pixel(make_pixel(0, 0, ChanMax, 0));
        send_pixel(make_pixel(90, 0, 123, ChanMax));
        send_pixel(make_pixel(ChanMax, 0, 1, 128));
    endtask

    task automatic test_zero_brightness();
        send_pixel(make_pixel(30, ChanMax, 0, ChanMax));
        send_pixel(make_pixel(150, 200, 0, 0));
        send_pixel(make_pixel(ChanMax, 0, 0, 255));
    endtask

    task automatic test_field_extremes();
        send_pixel(make_pixel(0, 0, 0, 0));
        send_pixel(make_pixel(ChanMax, ChanMax, ChanMax, ChanMax));
        send_pixel(make_pixel(ChanMax, ChanMax, 1, 0));
        send_pixel(make_pixel(0, 1, ChanMax, ChanMax));
    endtask

    task automatic test_random_pixels();
        repeat (RandomPixels)
        begin
            send_pixel(make_pixel(pick_byte(), pick_byte(), pick_byte(), $urandom_range(0, 255)));
        end
    endtask

    task automatic drain_and_report();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("%0d pixel words never came out", expected_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("hsv_to_rgb_8bit verification clean");
        end
        else
        begin
            $display("hsv_to_rgb_8bit verification failed");
        end
        $finish;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_hue_sectors();
        test_zero_saturation();
        test_zero_brightness();
        test_field_extremes();
        test_random_pixels();
        drain_and_report();
    end

    // output back-pressure: free-flowing, random, or mostly stalled stretches
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_pixels
        rgba_t want;
        rgba_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected output word %h", got);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red)
                begin
                    $error("red mismatch: expected %0d, actual %0d", want.red, got.red);
                    fail_count++;
                end
                if (got.green !== want.green)
                begin
                    $error("green mismatch: expected %0d, actual %0d", want.green, got.green);
                    fail_count++;
                end
                if (got.blue !== want.blue)
                begin
                    $error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
                    fail_count++;
                end
                if (got.alpha !== want.alpha)
                begin
                    $error("alpha_out mismatch: expected %0d, actual %0d",
                           want.alpha, got.alpha);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WatchdogLimit)
        begin
            $error("no word moved for %0d cycles", WatchdogLimit);
            $display("hsv_to_rgb_8bit verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
